// ----- rtl/core/rrip_pkg.sv -----
// ----------------------------------------------------------------------------
// rrip_pkg: shared types and constants of the RRIP replacement block
// Item kinds and the back stage sequencer states.
// ----------------------------------------------------------------------------
package rrip_pkg;

  localparam int unsigned AddrWidth = 64;
  localparam int unsigned RrpvMax = 3;
  localparam int unsigned StreamDetectCount = 3;
  localparam logic [1:0] StreamBypassRrpv = 2'd3;
  localparam int unsigned DipPselBits = 8;

  typedef enum logic {
    KIND_VICTIM = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  // Back stage sequencer: clear all rows after reset, then per item read the
  // set rows, then modify and write back
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_CLEAR
  } bk_state_t;

endpackage

// ----- rtl/core/rrip_ram.sv -----
// ----------------------------------------------------------------------------
// rrip_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rrip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/rrip_front.sv -----
// ----------------------------------------------------------------------------
// rrip_front: item intake
// Registers a command, folds the set index and checks the way range, then
// hands the item to a one-entry queue toward the back stage.
// ----------------------------------------------------------------------------
module rrip_front #(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         kind,
  input  logic [10:0]                  set_index,
  input  logic [15:0]                  valid_mask,
  input  logic [3:0]                   way,
  input  logic [rrip_pkg::AddrWidth-1:0] address,
  input  logic                         hit,
  input  logic [4:0]                   rand_drrip,
  input  logic [4:0]                   rand_dip,
  input  logic                         pop,
  input  logic                         hold,
  output logic                         full,
  output logic                         q_valid,
  output logic                         q_kind,
  output logic [$clog2(NUM_SETS)-1:0]  q_set,
  output logic [NUM_WAYS-1:0]          q_valid_mask,
  output logic [$clog2(NUM_WAYS)-1:0]  q_way,
  output logic                         q_way_ok,
  output logic [rrip_pkg::AddrWidth-1:0] q_address,
  output logic                         q_hit,
  output logic                         q_rd_zero,
  output logic                         q_rp_zero
);

  localparam int unsigned SetW = $clog2(NUM_SETS);
  localparam int unsigned WayW = $clog2(NUM_WAYS);

  logic [SetW-1:0]     set_fold;
  logic [NUM_WAYS-1:0] vmask;

  // Set index modulo the set count (a power of two); ways beyond 16 have no
  // valid bit
  always_comb begin
    set_fold = SetW'(32'(set_index) & (NUM_SETS - 1));
    for (int i = 0; i < NUM_WAYS; i++) begin
      vmask[i] = (i < 16) ? valid_mask[i % 16] : 1'b0;
    end
  end

  // No intake while the queue holds an item or the back stage is clearing
  assign full = q_valid || hold;

  // Queue valid
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (start && !full) begin
      q_valid <= 1'b1;
    end else if (pop) begin
      q_valid <= 1'b0;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (start && !full) begin
      q_kind       <= kind;
      q_set        <= set_fold;
      q_valid_mask <= vmask;
      q_way        <= WayW'(way);
      q_way_ok     <= 32'(way) < NUM_WAYS;
      q_address    <= address;
      q_hit        <= hit;
      q_rd_zero    <= rand_drrip == 5'd0;
      q_rp_zero    <= rand_dip == 5'd0;
    end
  end

endmodule

// ----- rtl/core/rrip_back.sv -----
// ----------------------------------------------------------------------------
// rrip_back: replacement state engine
// Reads a set's rows from RAM, computes victim or update, writes back and
// emits the result. After reset a clearing pass writes the reset rows into
// every set.
// ----------------------------------------------------------------------------
module rrip_back #(
  parameter int unsigned NUM_SETS       = 2048,
  parameter int unsigned NUM_WAYS       = 16,
  parameter int unsigned RRIP_LEADERS   = 64,
  parameter int unsigned DIP_LEADERS    = 32,
  parameter int unsigned SELECTOR_WIDTH = 10,
  parameter int unsigned HISTORY_DEPTH  = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  logic                          q_kind,
  input  logic [$clog2(NUM_SETS)-1:0]   q_set,
  input  logic [NUM_WAYS-1:0]           q_valid_mask,
  input  logic [$clog2(NUM_WAYS)-1:0]   q_way,
  input  logic                          q_way_ok,
  input  logic [rrip_pkg::AddrWidth-1:0] q_address,
  input  logic                          q_hit,
  input  logic                          q_rd_zero,
  input  logic                          q_rp_zero,
  output logic                          pop,
  output logic                          clearing,
  output logic                          done,
  output logic [3:0]                    victim_way,
  output logic [1:0]                    inserted_value,
  output logic                          streaming_seen,
  output logic [9:0]                    duel_selector
);

  localparam int unsigned SetW  = $clog2(NUM_SETS);
  localparam int unsigned WayW  = $clog2(NUM_WAYS);
  localparam int unsigned RowW  = 2 * NUM_WAYS;
  localparam int unsigned PtrW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned HistW = rrip_pkg::AddrWidth * HISTORY_DEPTH;
  localparam int unsigned DipW  = rrip_pkg::DipPselBits;
  localparam logic [SELECTOR_WIDTH-1:0] RMid = SELECTOR_WIDTH'(1) << (SELECTOR_WIDTH - 1);
  localparam logic [SELECTOR_WIDTH-1:0] RMax = '1;
  localparam logic [DipW-1:0] DMid = DipW'(1) << (DipW - 1);
  localparam logic [DipW-1:0] DMax = '1;

  rrip_pkg::bk_state_t state, state_next;

  // Clearing pass address and shared RAM address
  logic [SetW-1:0] clr_addr;
  logic [SetW-1:0] ram_addr;

  logic [RowW-1:0]  rr_rd, rc_rd, rr_wd, rc_wd;
  logic [HistW-1:0] hi_rd, hi_wd, hi_new;
  logic [PtrW-1:0]  hp_rd, hp_wd;
  logic             we;

  logic [SELECTOR_WIDTH-1:0] rsel;
  logic [DipW-1:0]           dsel;

  logic [RowW-1:0]  rr_cur, rc_cur;
  logic [HistW-1:0] hi_cur;
  logic [PtrW-1:0]  hp_cur;

  logic [WayW-1:0] vic;
  logic [1:0]      ins;
  logic            strm;
  logic            upd_fill;
  logic            r_srrip, r_brrip, d_lip, d_bip;

  assign clearing = state == rrip_pkg::BK_CLEAR;
  assign ram_addr = clearing ? clr_addr : q_set;

  rrip_ram #(.WIDTH(RowW), .DEPTH(NUM_SETS)) u_rr (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(rr_wd), .rdata(rr_rd));
  rrip_ram #(.WIDTH(RowW), .DEPTH(NUM_SETS)) u_rc (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(rc_wd), .rdata(rc_rd));
  rrip_ram #(.WIDTH(HistW), .DEPTH(NUM_SETS)) u_hi (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(hi_wd), .rdata(hi_rd));
  rrip_ram #(.WIDTH(PtrW), .DEPTH(NUM_SETS)) u_hp (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(hp_wd), .rdata(hp_rd));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrip_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SetW'(1);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrip_pkg::BK_IDLE:  if (q_valid) state_next = rrip_pkg::BK_READ;
      rrip_pkg::BK_READ:  state_next = rrip_pkg::BK_WRITE;
      rrip_pkg::BK_WRITE: state_next = rrip_pkg::BK_IDLE;
      rrip_pkg::BK_CLEAR: if (clr_addr == SetW'(NUM_SETS - 1)) state_next = rrip_pkg::BK_IDLE;
      default:            state_next = rrip_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    we  = 1'b0;
    pop = 1'b0;
    unique case (state)
      rrip_pkg::BK_WRITE: begin
        we  = 1'b1;
        pop = 1'b1;
      end
      rrip_pkg::BK_CLEAR: we = 1'b1;
      default: ;
    endcase
  end

  // Current rows
  always_comb begin
    rr_cur = rr_rd;
    rc_cur = rc_rd;
    hi_cur = hi_rd;
    hp_cur = hp_rd;
  end

  // Victim search and aging
  logic [1:0]      top;
  logic [1:0]      gap;
  logic            inv_found;
  logic [RowW-1:0] rr_aged;
  always_comb begin
    top       = 2'd0;
    inv_found = 1'b0;
    vic       = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (rr_cur[2*i +: 2] > top) top = rr_cur[2*i +: 2];
    end
    gap = 2'(rrip_pkg::RrpvMax) - top;
    for (int i = 0; i < NUM_WAYS; i++) begin
      rr_aged[2*i +: 2] = rr_cur[2*i +: 2] + gap;
    end
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (rr_aged[2*i +: 2] == 2'd3) begin
        vic = WayW'(i);
      end
    end
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (!q_valid_mask[i]) begin
        vic       = WayW'(i);
        inv_found = 1'b1;
      end
    end
  end

  // Streaming detector over the set history
  logic [PtrW-1:0]            hp_next;
  logic [rrip_pkg::AddrWidth-1:0] ref_stride;
  logic [4:0]                 match;
  always_comb begin
    hi_new = hi_cur;
    hi_new[rrip_pkg::AddrWidth*hp_cur +: rrip_pkg::AddrWidth] = q_address;
    hp_next = (32'(hp_cur) == HISTORY_DEPTH - 1) ? '0 : hp_cur + PtrW'(1);
    ref_stride = hi_new[rrip_pkg::AddrWidth +: rrip_pkg::AddrWidth] -
                 hi_new[0 +: rrip_pkg::AddrWidth];
    match = '0;
    for (int i = 2; i < HISTORY_DEPTH; i++) begin
      if (hi_new[rrip_pkg::AddrWidth*i +: rrip_pkg::AddrWidth] -
          hi_new[rrip_pkg::AddrWidth*(i-1) +: rrip_pkg::AddrWidth] == ref_stride)
        match = match + 5'd1;
    end
    strm = (32'(hp_cur) == HISTORY_DEPTH - 1) &&
           (32'(match) >= rrip_pkg::StreamDetectCount - 1);
  end

  // Insertion value
  logic [1:0] dv;
  always_comb begin
    r_srrip = 32'(q_set) < RRIP_LEADERS / 2;
    r_brrip = !r_srrip && 32'(q_set) < RRIP_LEADERS;
    d_lip   = 32'(q_set) < DIP_LEADERS / 2;
    d_bip   = !d_lip && 32'(q_set) < DIP_LEADERS;
    priority if (r_srrip) ins = 2'd2;
    else if (r_brrip)     ins = q_rd_zero ? 2'd2 : 2'd3;
    else                  ins = (rsel >= RMid) ? 2'd2 : (q_rd_zero ? 2'd2 : 2'd3);
    priority if (d_lip) dv = 2'd3;
    else if (d_bip)     dv = q_rp_zero ? 2'd3 : 2'd0;
    else                dv = (dsel >= DMid) ? 2'd3 : (q_rp_zero ? 2'd3 : 2'd0);
    if (rc_cur[2*q_way +: 2] >= 2'd2) ins = 2'd0;
    if (strm) ins = rrip_pkg::StreamBypassRrpv;
    if (d_lip || d_bip) ins = dv;
  end

  // Write-back data; the clearing pass writes the reset rows
  always_comb begin
    upd_fill = (q_kind == rrip_pkg::KIND_UPDATE) && q_way_ok && !q_hit;
    rr_wd = rr_cur;
    rc_wd = rc_cur;
    hi_wd = hi_cur;
    hp_wd = hp_cur;
    if (clearing) begin
      rr_wd = {NUM_WAYS{2'd3}};
      rc_wd = {NUM_WAYS{2'd1}};
      hi_wd = '0;
      hp_wd = '0;
    end else if (q_kind == rrip_pkg::KIND_VICTIM) begin
      if (!inv_found) rr_wd = rr_aged;
    end else if (q_way_ok) begin
      if (q_hit) begin
        rr_wd[2*q_way +: 2] = 2'd0;
        if (rc_cur[2*q_way +: 2] != 2'd3) rc_wd[2*q_way +: 2] = rc_cur[2*q_way +: 2] + 2'd1;
      end else begin
        rr_wd[2*q_way +: 2] = ins;
        rc_wd[2*q_way +: 2] = 2'd1;
        hi_wd = hi_new;
        hp_wd = hp_next;
      end
    end
  end

  // Selectors and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      rsel    <= RMid;
      dsel    <= DMid;
      done    <= 1'b0;
    end else begin
      done <= state == rrip_pkg::BK_WRITE;
      if (state == rrip_pkg::BK_WRITE) begin
        if (upd_fill) begin
          if (r_srrip && rsel != '0) rsel <= rsel - 1'b1;
          else if (r_brrip && rsel != RMax) rsel <= rsel + 1'b1;
          if (d_lip && dsel != '0) dsel <= dsel - 1'b1;
          else if (d_bip && dsel != DMax) dsel <= dsel + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rrip_pkg::BK_WRITE) begin
      victim_way     <= (q_kind == rrip_pkg::KIND_VICTIM) ? 4'(vic) : 4'd0;
      inserted_value <= upd_fill ? ins : 2'd0;
      streaming_seen <= upd_fill && strm;
    end
  end

  assign duel_selector = 10'(rsel);

endmodule

// ----- rtl/core/rrip_replacement_with_dueling.sv -----
// ----------------------------------------------------------------------------
// rrip_replacement_with_dueling: DRRIP replacement with set dueling
// Each item passes queue hand-off, row read, then modify and write-back of the
// set row in single-port RAM; a new item is accepted only after the back stage
// has taken the previous one from the queue.
// Reset: synchronous rst, then a clearing pass over all NUM_SETS sets (2048 by
// default) writes the reset rows with busy held high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rrip_replacement_with_dueling #(
  parameter int unsigned NUM_SETS       = 2048,
  parameter int unsigned NUM_WAYS       = 16,
  parameter int unsigned RRIP_LEADERS   = 64,
  parameter int unsigned DIP_LEADERS    = 32,
  parameter int unsigned SELECTOR_WIDTH = 10,
  parameter int unsigned HISTORY_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [10:0] set_index,
  input  logic [15:0] valid_mask,
  input  logic [3:0]  way,
  input  logic [63:0] address,
  input  logic        hit,
  input  logic [4:0]  rand_drrip,
  input  logic [4:0]  rand_dip,
  output logic        done,
  output logic [3:0]  victim_way,
  output logic [1:0]  inserted_value,
  output logic        streaming_seen,
  output logic [9:0]  duel_selector
);

  logic                        pop, q_valid, q_kind, q_way_ok, q_hit, q_rd_zero, q_rp_zero;
  logic                        clearing;
  logic [$clog2(NUM_SETS)-1:0] q_set;
  logic [NUM_WAYS-1:0]         q_valid_mask;
  logic [$clog2(NUM_WAYS)-1:0] q_way;
  logic [63:0]                 q_address;

  rrip_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_front (
    .clk, .rst, .start, .kind, .set_index, .valid_mask, .way, .address, .hit,
    .rand_drrip, .rand_dip, .pop, .hold(clearing), .full(busy), .q_valid, .q_kind,
    .q_set, .q_valid_mask, .q_way, .q_way_ok, .q_address, .q_hit, .q_rd_zero,
    .q_rp_zero);

  rrip_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .RRIP_LEADERS(RRIP_LEADERS),
    .DIP_LEADERS(DIP_LEADERS), .SELECTOR_WIDTH(SELECTOR_WIDTH),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk, .rst, .q_valid, .q_kind, .q_set, .q_valid_mask, .q_way, .q_way_ok,
    .q_address, .q_hit, .q_rd_zero, .q_rp_zero, .pop, .clearing, .done, .victim_way,
    .inserted_value, .streaming_seen, .duel_selector);

endmodule

// ----- dv/rrip_replacement_with_dueling_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrip_replacement_with_dueling_tb: self-checking bench for DRRIP replacement
// Sends victim requests, hits and miss fills through the command port in
// random bursts. A behavioral copy of the policy state predicts every result,
// and each done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module rrip_replacement_with_dueling_tb;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam int HDEPTH = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0] victim;
    logic [1:0] ins;
    logic       strm;
    logic [9:0] psel;
  } policy_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = 1'b0;
  logic [10:0] set_index = '0;
  logic [15:0] valid_mask = '0;
  logic [3:0]  way = '0;
  logic [63:0] address = '0;
  logic        hit = 1'b0;
  logic [4:0]  rand_drrip = '0;
  logic [4:0]  rand_dip = '0;
  logic        done;
  logic [3:0]  victim_way;
  logic [1:0]  inserted_value;
  logic        streaming_seen;
  logic [9:0]  duel_selector;

  // Predictor state
  logic [1:0]  rrpv_mem[NSETS][NWAYS];
  logic [1:0]  reuse_mem[NSETS][NWAYS];
  logic [63:0] hist_mem[NSETS][HDEPTH];
  int unsigned hist_ptr[NSETS];
  int unsigned rrip_psel;
  int unsigned dip_ctr;

  policy_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  rrip_replacement_with_dueling dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predict the result of one item and advance the policy state
  function automatic policy_result_t predict_policy(
      rrip_pkg::kind_t k, int unsigned s, logic [15:0] vm, int unsigned w, logic [63:0] a,
      logic h, logic [4:0] rd, logic [4:0] rp);
    policy_result_t r;
    int unsigned top, gap, p, match, dv;
    logic [63:0] ref_stride;
    bit st, r_s, r_b, d_l, d_b, found;
    r = '0;
    found = 0;
    if (k == rrip_pkg::KIND_VICTIM) begin
      for (int i = 0; i < NWAYS; i++)
        if (!found && !vm[i]) begin
          r.victim = i[3:0];
          found = 1;
        end
      if (!found) begin
        top = 0;
        for (int i = 0; i < NWAYS; i++) if (rrpv_mem[s][i] > top) top = rrpv_mem[s][i];
        gap = rrip_pkg::RrpvMax - top;
        for (int i = 0; i < NWAYS; i++) rrpv_mem[s][i] = rrpv_mem[s][i] + gap[1:0];
        for (int i = NWAYS - 1; i >= 0; i--)
          if (rrpv_mem[s][i] == rrip_pkg::RrpvMax) r.victim = i[3:0];
      end
    end else if (h) begin
      rrpv_mem[s][w] = 2'd0;
      if (reuse_mem[s][w] < 2'd3) reuse_mem[s][w] = reuse_mem[s][w] + 2'd1;
    end else begin
      // streaming detector on the per-set address history
      p = hist_ptr[s];
      hist_mem[s][p] = a;
      hist_ptr[s] = (p + 1) % HDEPTH;
      st = 0;
      if (p == HDEPTH - 1) begin
        ref_stride = hist_mem[s][1] - hist_mem[s][0];
        match = 0;
        for (int i = 2; i < HDEPTH; i++)
          if (hist_mem[s][i] - hist_mem[s][i-1] == ref_stride) match++;
        st = (match >= rrip_pkg::StreamDetectCount - 1);
      end
      r_s = s < 32;
      r_b = !r_s && s < 64;
      d_l = s < 16;
      d_b = !d_l && s < 32;
      if (r_s) r.ins = 2'd2;
      else if (r_b) r.ins = (rd == 0) ? 2'd2 : 2'd3;
      else r.ins = (rrip_psel >= 512) ? 2'd2 : ((rd == 0) ? 2'd2 : 2'd3);
      if (d_l) dv = 3;
      else if (d_b) dv = (rp == 0) ? 3 : 0;
      else dv = (dip_ctr >= 128) ? 3 : ((rp == 0) ? 3 : 0);
      if (reuse_mem[s][w] >= 2) r.ins = 2'd0;
      if (st) r.ins = rrip_pkg::StreamBypassRrpv;
      if (d_l || d_b) r.ins = dv[1:0];
      rrpv_mem[s][w] = r.ins;
      reuse_mem[s][w] = 2'd1;
      r.strm = st;
      if (r_s) begin
        if (rrip_psel > 0) rrip_psel--;
      end else if (r_b) begin
        if (rrip_psel < 1023) rrip_psel++;
      end
      if (d_l) begin
        if (dip_ctr > 0) dip_ctr--;
      end else if (d_b) begin
        if (dip_ctr < 255) dip_ctr++;
      end
    end
    r.psel = rrip_psel[9:0];
    return r;
  endfunction

  // Send one item: random gaps between bursts, then wait for acceptance
  task automatic send_item(rrip_pkg::kind_t k, int unsigned s, logic [15:0] vm,
                           int unsigned w, logic [63:0] a, logic h, logic [4:0] rd,
                           logic [4:0] rp);
    int unsigned gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_len = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
      if (gap_len != 0) begin
        start <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    kind <= k;
    set_index <= s[10:0];
    valid_mask <= vm;
    way <= w[3:0];
    address <= a;
    hit <= h;
    rand_drrip <= rd;
    rand_dip <= rp;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_policy(k, s, vm, w, a, h, rd, rp));
  endtask

  // Check every done strobe against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result victim=%0d", $time, victim_way);
        errors++;
      end else begin
        policy_result_t e;
        e = expected_q.pop_front();
        if (victim_way !== e.victim) begin
          $display("%0t: victim_way exp %0d got %0d", $time, e.victim, victim_way);
          errors++;
        end
        if (inserted_value !== e.ins) begin
          $display("%0t: inserted_value exp %0d got %0d", $time, e.ins, inserted_value);
          errors++;
        end
        if (streaming_seen !== e.strm) begin
          $display("%0t: streaming_seen exp %0d got %0d", $time, e.strm, streaming_seen);
          errors++;
        end
        if (duel_selector !== e.psel) begin
          $display("%0t: duel_selector exp %0d got %0d", $time, e.psel, duel_selector);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Corner cases: full and empty masks, aging, streaming, leader regions
  task automatic test_directed();
    send_item(rrip_pkg::KIND_VICTIM, 100, 16'h0000, 0, '0, 0, 0, 0);
    send_item(rrip_pkg::KIND_VICTIM, 100, 16'h7FFF, 0, '0, 0, 0, 0);
    send_item(rrip_pkg::KIND_UPDATE, 100, 16'hFFFF, 15, '0, 1, 31, 31);
    send_item(rrip_pkg::KIND_UPDATE, 100, 16'hFFFF, 0, '0, 1, 0, 0);
    send_item(rrip_pkg::KIND_VICTIM, 100, 16'hFFFF, 0, '0, 0, 0, 0);
    // constant stride fills, then a broken stride
    for (int i = 0; i < 4; i++)
      send_item(rrip_pkg::KIND_UPDATE, 2047, '0, i, 64'hFFFF_FFFF_FFFF_FFC0 + 64*i, 0,
                31, 31);
    for (int i = 0; i < 4; i++)
      send_item(rrip_pkg::KIND_UPDATE, 2047, '0, 3, (i == 2) ? 64'd7 : 64'd128*i, 0, 0, 0);
    send_item(rrip_pkg::KIND_UPDATE, 0, '0, 5, '1, 0, 0, 0);
    send_item(rrip_pkg::KIND_UPDATE, 20, '0, 5, '1, 0, 31, 0);
    send_item(rrip_pkg::KIND_UPDATE, 40, '0, 5, '1, 0, 0, 31);
    send_item(rrip_pkg::KIND_UPDATE, 1000, '0, 5, '1, 0, 31, 31);
    send_item(rrip_pkg::KIND_UPDATE, 1000, '0, 5, '0, 1, 0, 0);
    send_item(rrip_pkg::KIND_UPDATE, 1000, '0, 5, '0, 1, 0, 0);
    send_item(rrip_pkg::KIND_UPDATE, 1000, '0, 5, '0, 0, 0, 0);
    send_item(rrip_pkg::KIND_VICTIM, 1000, 16'hFFFF, 0, '0, 0, 0, 0);
  endtask

  // Drive the DRRIP selector down to zero with leader misses, then back up
  // past the midpoint so followers see both insertion choices
  task automatic test_selector_extremes();
    repeat (530) send_item(rrip_pkg::KIND_UPDATE, $urandom_range(0, 31), '0,
                           $urandom_range(0, 15), rand64(), 0, 5'($urandom()),
                           5'($urandom()));
    repeat (20) send_item(rrip_pkg::KIND_UPDATE, $urandom_range(64, 2047), '0,
                          $urandom_range(0, 15), rand64(), 0,
                          5'($urandom_range(0, 1) ? 0 : $urandom()), 5'($urandom()));
    repeat (530) send_item(rrip_pkg::KIND_UPDATE, $urandom_range(32, 63), '0,
                           $urandom_range(0, 15), rand64(), 0, 5'($urandom()),
                           5'($urandom()));
  endtask

  // Random mix on a few hot sets so history, reuse and aging all interact
  task automatic test_random_mix();
    int unsigned s, stride, base;
    for (int n = 0; n < 400; n++) begin
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                      : {$urandom_range(0, 7), 3'b0} + $urandom_range(0, 1) * 1024;
      case ($urandom_range(0, 5))
        0: send_item(rrip_pkg::KIND_VICTIM, s,
                     16'($urandom_range(0, 3) ? 16'hFFFF : $urandom()), 0, rand64(),
                     1'($urandom()), 5'($urandom()), 5'($urandom()));
        1, 2: send_item(rrip_pkg::KIND_UPDATE, s, 16'($urandom()), $urandom_range(0, 15),
                        rand64(), 1, 5'($urandom()), 5'($urandom()));
        3: send_item(rrip_pkg::KIND_UPDATE, s, 16'($urandom()), $urandom_range(0, 15),
                     rand64(), 0, 5'($urandom_range(0, 1) ? 0 : $urandom()),
                     5'($urandom_range(0, 1) ? 0 : $urandom()));
        default: begin
          stride = $urandom();
          base = $urandom();
          for (int i = 0; i < 4; i++)
            send_item(rrip_pkg::KIND_UPDATE, s, 16'($urandom()), $urandom_range(0, 15),
                      {32'(base >> 3), 32'(base + stride * i)}, 0, 5'($urandom()),
                      5'($urandom()));
          n += 3;
        end
      endcase
    end
  endtask

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        rrpv_mem[s][w] = 2'd3;
        reuse_mem[s][w] = 2'd1;
      end
      for (int i = 0; i < HDEPTH; i++) hist_mem[s][i] = '0;
      hist_ptr[s] = 0;
    end
    rrip_psel = 512;
    dip_ctr = 128;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_selector_extremes();
    test_random_mix();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rrip_pkg.sv
rtl/core/rrip_ram.sv
rtl/core/rrip_front.sv
rtl/core/rrip_back.sv
rtl/core/rrip_replacement_with_dueling.sv
dv/rrip_replacement_with_dueling_tb.sv
